>>> sv/smj_pkg.sv
// smj_pkg: shared types, constants and the CORDIC arctangent table for
// spherical_momentum_jacobian. No dependencies.
`timescale 1ns / 1ps
package smj_pkg;

  localparam int EnergyBits     = 24;
  localparam int TrigIterations = 16;
  localparam int CordicSteps    = (TrigIterations < 24) ? TrigIterations : 24;
  localparam int CntW           = $clog2(CordicSteps + 1);

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [1:0] {
    CFG_ENERGY  = 2'd0,
    CFG_POLAR   = 2'd1,
    CFG_AZIMUTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TH_START,
    ST_TH_RUN,
    ST_PH_START,
    ST_PH_RUN,
    ST_MUL_PT,
    ST_MUL_PZ,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_DXE,
    ST_MUL_DYE,
    ST_MUL_DXT,
    ST_MUL_DYT,
    ST_MUL_LAST,
    ST_OUT
  } state_e;

  // Control from the sequencer to the CORDIC unit
  typedef struct packed {
    logic               start;
    logic signed [16:0] angle;
  } cordic_ctl_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      unique case (i)
        5'd0:  r = 34'sh20000000;
        5'd1:  r = 34'sh12E4051E;
        5'd2:  r = 34'sh09FB385B;
        5'd3:  r = 34'sh051111D4;
        5'd4:  r = 34'sh028B0D43;
        5'd5:  r = 34'sh0145D7E1;
        5'd6:  r = 34'sh00A2F61E;
        5'd7:  r = 34'sh00517C55;
        5'd8:  r = 34'sh0028BE53;
        5'd9:  r = 34'sh00145F2F;
        5'd10: r = 34'sh000A2F98;
        5'd11: r = 34'sh000517CC;
        5'd12: r = 34'sh00028BE6;
        5'd13: r = 34'sh000145F3;
        5'd14: r = 34'sh0000A2FA;
        5'd15: r = 34'sh0000517D;
        5'd16: r = 34'sh000028BE;
        5'd17: r = 34'sh0000145F;
        5'd18: r = 34'sh00000A30;
        5'd19: r = 34'sh00000518;
        5'd20: r = 34'sh0000028C;
        5'd21: r = 34'sh00000146;
        5'd22: r = 34'sh000000A3;
        5'd23: r = 34'sh00000051;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // Round-half-up Q2.30 -> Q1.15 with saturation to +-32768
  function automatic logic signed [16:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [19:0] r;
    begin
      t = 35'(v) + 35'sd16384;
      r = 20'(t >>> 15);
      if (r > 20'sd32768) r = 20'sd32768;
      else if (r < -20'sd32768) r = -20'sd32768;
      return 17'(r);
    end
  endfunction

endpackage

>>> sv/smj_cordic.sv
// smj_cordic: rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on smj_pkg.
`timescale 1ns / 1ps
module smj_cordic (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  smj_pkg::cordic_ctl_t     ctl_i,
  output logic                     done_o,
  output logic signed [16:0]       sin_o,
  output logic signed [16:0]       cos_o
);

  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [smj_pkg::CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, neg_q, neg_d;
  logic signed [16:0] a;
  logic signed [33:0] xs, ys;

  // Quadrant fold and rotation step
  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; cnt_d = cnt_q; busy_d = busy_q; neg_d = neg_q;
    a  = ctl_i.angle;
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    if (ctl_i.start) begin
      neg_d = 1'b0;
      if (a > 17'sd16384) begin
        a = a - 17'sd32768; neg_d = 1'b1;
      end else if (a < -17'sd16384) begin
        a = a + 17'sd32768; neg_d = 1'b1;
      end
      x_d = smj_pkg::CordicGain;
      y_d = '0;
      z_d = 34'(a) <<< 16;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - ys; y_d = y_q + xs;
        z_d = z_q - smj_pkg::atan_entry(5'(cnt_q));
      end else begin
        x_d = x_q + ys; y_d = y_q - xs;
        z_d = z_q + smj_pkg::atan_entry(5'(cnt_q));
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == smj_pkg::CntW'(smj_pkg::CordicSteps - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; neg_q <= neg_d;
  end

  assign done_o = !busy_q;
  assign cos_o  = neg_q ? -smj_pkg::to_q15(x_q) : smj_pkg::to_q15(x_q);
  assign sin_o  = neg_q ? -smj_pkg::to_q15(y_q) : smj_pkg::to_q15(y_q);

endmodule

>>> sv/smj_mul.sv
// smj_mul: shared registered Q1.15 rounding multiplier, floor((a*b+16384)/32768).
// Depends on smj_pkg.
`timescale 1ns / 1ps
module smj_mul (
  input  logic                                  clk_i,
  input  logic signed [smj_pkg::EnergyBits:0]   a_i,
  input  logic signed [16:0]                    b_i,
  output logic signed [smj_pkg::EnergyBits:0]   p_o
);

  localparam int PW = smj_pkg::EnergyBits + 18;
  logic signed [PW-1:0] prod;

  // Rounded product, truncated to the result width
  always_comb begin
    prod = PW'(a_i) * PW'(b_i) + PW'(16384);
  end

  always_ff @(posedge clk_i) begin
    p_o <= (smj_pkg::EnergyBits + 1)'(prod >>> 15);
  end

endmodule

>>> sv/spherical_momentum_jacobian.sv
// Top level: normalization, change test, sequencer and result register.
// Depends on smj_pkg, smj_cordic, smj_mul.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes energy, polar and azimuth.
//   Output channel (out_valid_o/out_ready_i) delivers one result per input.
//   Config channel (cfg_valid_i/cfg_ready_o) writes the three change limits
//   by index; it is always ready. Write only while the block is idle.
//   Each angle runs on the single CORDIC rotator: a start state,
//   TrigIterations rotations and a capture. Then the shared multiplier
//   steps through ST_MUL_PT to ST_MUL_DYT, and ST_MUL_LAST lands the
//   last product. out_valid_o is high in ST_OUT, after every result has
//   landed; one item is in flight at a time.
//   in_ready_o is high only in the idle state; a new item is not taken
//   until the previous result has been accepted.
//   When the receiver stalls, the result is held in its register unchanged.
//   Reset clears the limits and the stored previous parameters to zero.
module spherical_momentum_jacobian (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [smj_pkg::EnergyBits-1:0]  energy_in_i,
  input  logic signed [15:0]                     polar_in_i,
  input  logic signed [15:0]                     azimuth_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [15:0]                            polar_norm_o,
  output logic signed [15:0]                     azimuth_norm_o,
  output logic                                   changed_o,
  output logic [smj_pkg::EnergyBits-1:0]         trans_mom_o,
  output logic signed [smj_pkg::EnergyBits:0]    mom_x_o,
  output logic signed [smj_pkg::EnergyBits:0]    mom_y_o,
  output logic signed [smj_pkg::EnergyBits:0]    mom_z_o,
  output logic signed [16:0]                     dx_de_o,
  output logic signed [16:0]                     dy_de_o,
  output logic signed [16:0]                     dz_de_o,
  output logic signed [smj_pkg::EnergyBits:0]    dx_dtheta_o,
  output logic signed [smj_pkg::EnergyBits:0]    dy_dtheta_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [1:0]                             cfg_index_i,
  input  logic [47:0]                            cfg_data_i
);

  localparam int EB = smj_pkg::EnergyBits;

  smj_pkg::state_e state_q, state_d;
  logic [47:0] e_lim_q;
  logic [30:0] th_lim_q, ph_lim_q;
  logic signed [EB:0] last_e_q, e_q;
  logic signed [16:0] last_th_q, th_q;
  logic signed [15:0] last_ph_q, ph_q;
  logic chg_q;
  logic signed [16:0] sth_q, cth_q, sph_q, cph_q;
  logic signed [EB:0] pt_q, pz_q;

  logic in_acc;
  logic signed [EB:0] e_n;
  logic signed [17:0] th_n, ph_t;
  logic signed [15:0] ph_n;
  logic signed [EB+1:0] de;
  logic [EB:0] de_abs;
  logic signed [17:0] dth;
  logic [16:0] dth_abs;
  logic signed [15:0] dph;
  logic [16:0] dph_abs;
  logic [2*EB+1:0] de_sq;
  logic [33:0] dth_sq, dph_sq;
  logic chg_n;

  smj_pkg::cordic_ctl_t cctl;
  logic cdone;
  logic signed [16:0] csin, ccos;
  logic signed [EB:0] ma;
  logic signed [16:0] mb;
  logic signed [EB:0] mp;

  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Input normalization
  always_comb begin
    e_n  = (EB+1)'(energy_in_i);
    th_n = 18'(polar_in_i);
    ph_t = 18'(azimuth_in_i);
    if (energy_in_i < 0) begin
      e_n  = -e_n;
      th_n = 18'sd32768 - th_n;
      ph_t = ph_t + 18'sd32768;
    end
    if (th_n < 0) begin
      th_n = -th_n;
      ph_t = ph_t + 18'sd32768;
    end else if (th_n > 18'sd32768) begin
      th_n = 18'sd65536 - th_n;
      ph_t = ph_t + 18'sd32768;
    end
    ph_n = ph_t[15:0];
  end

  // Change test against the stored parameters
  always_comb begin
    de      = (EB+2)'(e_n) - (EB+2)'(last_e_q);
    de_abs  = de[EB+1] ? (EB+1)'(-de) : (EB+1)'(de);
    dth     = th_n - 18'(last_th_q);
    dth_abs = dth[17] ? 17'(-dth) : 17'(dth);
    dph     = ph_n - last_ph_q;
    dph_abs = dph[15] ? 17'(-18'(dph)) : 17'(dph);
    de_sq   = de_abs * de_abs;
    dth_sq  = dth_abs * dth_abs;
    dph_sq  = dph_abs * dph_abs;
    chg_n   = (48'(de_sq) > e_lim_q) || (dth_sq > 34'(th_lim_q))
           || (dph_sq > 34'(ph_lim_q));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smj_pkg::ST_IDLE:     if (in_acc) state_d = smj_pkg::ST_TH_START;
      smj_pkg::ST_TH_START: state_d = smj_pkg::ST_TH_RUN;
      smj_pkg::ST_TH_RUN:   if (cdone) state_d = smj_pkg::ST_PH_START;
      smj_pkg::ST_PH_START: state_d = smj_pkg::ST_PH_RUN;
      smj_pkg::ST_PH_RUN:   if (cdone) state_d = smj_pkg::ST_MUL_PT;
      smj_pkg::ST_MUL_PT:   state_d = smj_pkg::ST_MUL_PZ;
      smj_pkg::ST_MUL_PZ:   state_d = smj_pkg::ST_MUL_X;
      smj_pkg::ST_MUL_X:    state_d = smj_pkg::ST_MUL_Y;
      smj_pkg::ST_MUL_Y:    state_d = smj_pkg::ST_MUL_DXE;
      smj_pkg::ST_MUL_DXE:  state_d = smj_pkg::ST_MUL_DYE;
      smj_pkg::ST_MUL_DYE:  state_d = smj_pkg::ST_MUL_DXT;
      smj_pkg::ST_MUL_DXT:  state_d = smj_pkg::ST_MUL_DYT;
      smj_pkg::ST_MUL_DYT:  state_d = smj_pkg::ST_MUL_LAST;
      smj_pkg::ST_MUL_LAST: state_d = smj_pkg::ST_OUT;
      smj_pkg::ST_OUT:      if (out_ready_i) state_d = smj_pkg::ST_IDLE;
      default:              state_d = smj_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: CORDIC start, multiplier operands, in_ready_o and out_valid_o
  always_comb begin
    cctl.start = 1'b0;
    cctl.angle = th_q;
    ma = e_q;
    mb = sth_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      smj_pkg::ST_IDLE:     in_ready_o = 1'b1;
      smj_pkg::ST_TH_START: cctl.start = 1'b1;
      smj_pkg::ST_PH_START: begin
        cctl.start = 1'b1;
        cctl.angle = 17'(ph_q);
      end
      smj_pkg::ST_MUL_PT:   begin ma = e_q;  mb = sth_q; end
      smj_pkg::ST_MUL_PZ:   begin ma = e_q;  mb = cth_q; end
      smj_pkg::ST_MUL_X:    begin ma = pt_q; mb = cph_q; end
      smj_pkg::ST_MUL_Y:    begin ma = pt_q; mb = sph_q; end
      smj_pkg::ST_MUL_DXE:  begin ma = (EB+1)'(sth_q); mb = cph_q; end
      smj_pkg::ST_MUL_DYE:  begin ma = (EB+1)'(sth_q); mb = sph_q; end
      smj_pkg::ST_MUL_DXT:  begin ma = pz_q; mb = cph_q; end
      smj_pkg::ST_MUL_DYT:  begin ma = pz_q; mb = sph_q; end
      smj_pkg::ST_OUT:      out_valid_o = 1'b1;
      default:              ;
    endcase
  end

  smj_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .done_o (cdone),
    .sin_o  (csin),
    .cos_o  (ccos)
  );

  smj_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (mp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smj_pkg::ST_IDLE;
      e_lim_q   <= '0;
      th_lim_q  <= '0;
      ph_lim_q  <= '0;
      last_e_q  <= '0;
      last_th_q <= '0;
      last_ph_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          smj_pkg::CFG_ENERGY:  e_lim_q  <= cfg_data_i;
          smj_pkg::CFG_POLAR:   th_lim_q <= cfg_data_i[30:0];
          smj_pkg::CFG_AZIMUTH: ph_lim_q <= cfg_data_i[30:0];
          default:              ;
        endcase
      end
      if (in_acc) begin
        last_e_q  <= e_n;
        last_th_q <= 17'(th_n);
        last_ph_q <= ph_n;
      end
    end
  end

  // Datapath registers; each product is captured in the state after its operands
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q <= e_n; th_q <= 17'(th_n); ph_q <= ph_n; chg_q <= chg_n;
    end
    if (state_q == smj_pkg::ST_TH_RUN && cdone) begin
      sth_q <= (csin < 0) ? 17'sd0 : csin;
      cth_q <= ccos;
    end
    if (state_q == smj_pkg::ST_PH_RUN && cdone) begin
      sph_q <= csin; cph_q <= ccos;
    end
    unique case (state_q)
      smj_pkg::ST_MUL_PZ:   pt_q <= mp;
      smj_pkg::ST_MUL_X:    pz_q <= mp;
      smj_pkg::ST_MUL_Y:    mom_x_o <= mp;
      smj_pkg::ST_MUL_DXE:  mom_y_o <= mp;
      smj_pkg::ST_MUL_DYE:  dx_de_o <= mp[16:0];
      smj_pkg::ST_MUL_DXT:  dy_de_o <= mp[16:0];
      smj_pkg::ST_MUL_DYT:  dx_dtheta_o <= mp;
      smj_pkg::ST_MUL_LAST: dy_dtheta_o <= mp;
      default:              ;
    endcase
  end

  assign polar_norm_o   = 16'(th_q);
  assign azimuth_norm_o = ph_q;
  assign changed_o      = chg_q;
  assign trans_mom_o    = pt_q[EB-1:0];
  assign mom_z_o        = pz_q;
  assign dz_de_o        = cth_q;

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready while result pending");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_start_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> cctl.start) else $error("CORDIC not started after accept");
`endif

endmodule

>>> tb/testbench.sv
// Testbench for spherical_momentum_jacobian. A queue-fed driver, a checking
// monitor and a built-in predictor cover several change-limit settings.
// Depends on smj_pkg and the RTL of spherical_momentum_jacobian.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic signed [23:0] energy;
    logic signed [15:0] polar;
    logic signed [15:0] azimuth;
  } kin_item_t;

  typedef struct {
    logic [15:0] polar;
    logic [15:0] azimuth;
    logic        changed;
    logic [23:0] pt;
    logic [24:0] px, py, pz;
    logic [16:0] dxe, dye, dze;
    logic [24:0] dxt, dyt;
  } kin_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [23:0] energy_in_i = '0;
  logic signed [15:0] polar_in_i = '0;
  logic signed [15:0] azimuth_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] polar_norm_o;
  logic signed [15:0] azimuth_norm_o;
  logic changed_o;
  logic [23:0] trans_mom_o;
  logic signed [24:0] mom_x_o, mom_y_o, mom_z_o;
  logic signed [16:0] dx_de_o, dy_de_o, dz_de_o;
  logic signed [24:0] dx_dtheta_o, dy_dtheta_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = smj_pkg::CFG_ENERGY;
  logic [47:0] cfg_data_i = '0;

  kin_item_t   pending_items[$];
  kin_result_t expected_kin[$];
  int errors = 0;
  int results_seen = 0;
  bit quiet = 1'b0;

  // predictor copy of limits and stored parameters
  longint energy_lim = 0, polar_lim = 0, azimuth_lim = 0;
  longint prev_energy = 0, prev_polar = 0, prev_azimuth = 0;

  localparam longint AtanQ32[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  spherical_momentum_jacobian dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint scale_q15(longint a, longint b);
    return (a * b + 64'sd16384) >>> 15;
  endfunction

  function automatic longint wrap_angle(longint v);
    longint u;
    u = v & 64'hFFFF;
    return (u >= 32768) ? u - 65536 : u;
  endfunction

  // rotation-mode CORDIC on a binary angle
  task automatic cordic_sincos(input longint ang, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (ang > 16384) begin
      ang -= 32768;
      flip = 1'b1;
    end else if (ang < -16384) begin
      ang += 32768;
      flip = 1'b1;
    end
    z = ang * 65536;
    for (int i = 0; i < smj_pkg::CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= AtanQ32[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += AtanQ32[i];
      end
      x = nx;
    end
    c = round_q15(x);
    s = round_q15(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic longint sq_mag(longint d);
    return (d < 0) ? d * d : d * d;
  endfunction

  // momentum and Jacobian for one transaction; updates stored parameters
  task automatic predict_kinematics(input kin_item_t it, output kin_result_t r);
    longint e, th, ph, sth, cth, sph, cph, pt, pz;
    e = it.energy;
    th = it.polar;
    ph = it.azimuth;
    if (e < 0) begin
      e = -e;
      th = 32768 - th;
      ph += 32768;
    end
    if (th < 0) begin
      th = -th;
      ph += 32768;
    end else if (th > 32768) begin
      th = 65536 - th;
      ph += 32768;
    end
    ph = wrap_angle(ph);
    r.changed = (sq_mag(e - prev_energy) > energy_lim) ||
                (sq_mag(th - prev_polar) > polar_lim) ||
                (sq_mag(wrap_angle(ph - prev_azimuth)) > azimuth_lim);
    prev_energy = e;
    prev_polar = th;
    prev_azimuth = ph;
    cordic_sincos(th, sth, cth);
    cordic_sincos(ph, sph, cph);
    if (sth < 0) sth = 0;
    pt = scale_q15(e, sth);
    pz = scale_q15(e, cth);
    r.polar = th[15:0];
    r.azimuth = ph[15:0];
    r.pt = pt[23:0];
    r.px = 25'(scale_q15(pt, cph));
    r.py = 25'(scale_q15(pt, sph));
    r.pz = pz[24:0];
    r.dxe = 17'(scale_q15(sth, cph));
    r.dye = 17'(scale_q15(sth, sph));
    r.dze = cth[16:0];
    r.dxt = 25'(scale_q15(pz, cph));
    r.dyt = 25'(scale_q15(pz, sph));
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at result %0d: got %h expected %h",
             what, results_seen, got, want);
    errors++;
  endtask

  // input driver with random gap bursts
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    kin_item_t it;
    kin_result_t r;
    logic nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        it.energy = energy_in_i;
        it.polar = polar_in_i;
        it.azimuth = azimuth_in_i;
        predict_kinematics(it, r);
        expected_kin.push_back(r);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          if (!quiet && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(0, 15);
          end else begin
            it = pending_items.pop_front();
            energy_in_i <= it.energy;
            polar_in_i <= it.polar;
            azimuth_in_i <= it.azimuth;
            nxt_valid = 1'b1;
          end
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // result monitor with random stall bursts
  int recv_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    kin_result_t w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_kin.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = expected_kin.pop_front();
          if (polar_norm_o !== w.polar) report_mismatch("polar_norm", polar_norm_o, w.polar);
          if (azimuth_norm_o !== w.azimuth)
            report_mismatch("azimuth_norm", azimuth_norm_o, w.azimuth);
          if (changed_o !== w.changed) report_mismatch("changed", changed_o, w.changed);
          if (trans_mom_o !== w.pt) report_mismatch("trans_mom", trans_mom_o, w.pt);
          if (mom_x_o !== w.px) report_mismatch("mom_x", mom_x_o, w.px);
          if (mom_y_o !== w.py) report_mismatch("mom_y", mom_y_o, w.py);
          if (mom_z_o !== w.pz) report_mismatch("mom_z", mom_z_o, w.pz);
          if (dx_de_o !== w.dxe) report_mismatch("dx_de", dx_de_o, w.dxe);
          if (dy_de_o !== w.dye) report_mismatch("dy_de", dy_de_o, w.dye);
          if (dz_de_o !== w.dze) report_mismatch("dz_de", dz_de_o, w.dze);
          if (dx_dtheta_o !== w.dxt) report_mismatch("dx_dtheta", dx_dtheta_o, w.dxt);
          if (dy_dtheta_o !== w.dyt) report_mismatch("dy_dtheta", dy_dtheta_o, w.dyt);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // one register write transaction
  task automatic write_limit(smj_pkg::cfg_idx_e idx, logic [47:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      smj_pkg::CFG_ENERGY:  energy_lim = data;
      smj_pkg::CFG_POLAR:   polar_lim = data[30:0];
      smj_pkg::CFG_AZIMUTH: azimuth_lim = data[30:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_limits(logic [47:0] e, logic [47:0] p, logic [47:0] a);
    write_limit(smj_pkg::CFG_ENERGY, e);
    write_limit(smj_pkg::CFG_POLAR, p);
    write_limit(smj_pkg::CFG_AZIMUTH, a);
  endtask

  // wait for every result, then let the block settle
  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_kin.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic queue_item(int e, int p, int a);
    kin_item_t it;
    it.energy = 24'(e);
    it.polar = 16'(p);
    it.azimuth = 16'(a);
    pending_items.push_back(it);
  endtask

  // random items: half small moves from the last one, half wide jumps
  int rnd_e = 0, rnd_p = 0, rnd_a = 0;
  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          rnd_e = $urandom;
          rnd_p = $urandom;
          rnd_a = $urandom;
        end
        1: begin
          rnd_e = $urandom_range(0, 1) ? -8388608 : 8388607;
          rnd_p = $urandom_range(0, 1) ? -32768 : 32767;
          rnd_a = $urandom;
        end
        2: begin
          rnd_e = int'($urandom_range(0, 4095)) - 2048;
          rnd_p = $urandom;
          rnd_a = $urandom;
        end
        default: begin
          rnd_e += int'($urandom_range(0, 4000)) - 2000;
          rnd_p += int'($urandom_range(0, 400)) - 200;
          rnd_a += int'($urandom_range(0, 400)) - 200;
        end
      endcase
      rnd_e = (rnd_e <<< 8) >>> 8;
      rnd_p = (rnd_p <<< 16) >>> 16;
      rnd_a = (rnd_a <<< 16) >>> 16;
      queue_item(rnd_e, rnd_p, rnd_a);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero energy, sign flips, theta folding, phi wrap
    set_limits(48'd0, 48'd0, 48'd0);
    queue_item(0, 0, 0);
    queue_item(0, 0, 0);
    queue_item(8388607, 16384, 0);
    queue_item(-8388608, 16384, 16384);
    queue_item(-1, 0, -32768);
    queue_item(1, 32767, 32767);
    queue_item(8388607, -32768, -32768);
    queue_item(8388607, -1, 32767);
    queue_item(-8388608, -32768, 0);
    queue_item(1000000, -16384, 12345);
    queue_item(-1000000, 20000, -20000);
    queue_item(5000000, 16384, 16384);
    queue_item(5000000, 16384, -16384);
    queue_item(5000000, 8192, 24576);
    queue_item(0, 32767, -32768);
    queue_item(8388607, 0, 0);
    queue_item(8388607, 0, 0);
    queue_item(-8388608, 32767, -1);
    drain();

    set_limits(48'd1000000, 48'd10000, 48'd10000);
    queue_random(300);
    drain();

    set_limits(48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF, 48'h7FFF_FFFF);
    queue_random(300);
    drain();

    set_limits(48'({$urandom, $urandom}), 48'h4000_0000, 48'({$urandom, $urandom}));
    queue_random(100);
    drain();

    set_limits(48'd4000000, 48'd40000, 48'd40000);
    queue_random(300);
    drain();

    quiet = 1'b1;
    set_limits({16'h0, $urandom}, {32'h0, 16'($urandom)}, 48'hFFFF_8000_0001);
    queue_random(350);
    drain();

    $display("checked %0d results over six limit settings, covering sign flips,",
             results_seen);
    $display("polar folding, azimuth wrap and the change flag under idle and stall");
    if (errors == 0 && expected_kin.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
